// ===== src/mhss_pkg.sv =====
package mhss_pkg;

   localparam int WordWidth = 64;
   localparam int SiteWidth = 33;
   localparam int CountWidth = 7;
   localparam int BinWidth = 32;

   typedef enum logic [2:0] {
      CSR_QUERY_FWD  = 3'd0,
      CSR_QUERY_REV  = 3'd1,
      CSR_SEQ_LEN    = 3'd2,
      CSR_ID_OFFSET  = 3'd3,
      CSR_LIST_LIMIT = 3'd4,
      CSR_ERROR_WORD = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic                  check;
      logic [CountWidth-1:0] mm;
      logic [SiteWidth-1:0]  site_id;
      logic                  last;
   } fe_item_type;

   typedef struct packed {
      logic                  kind;
      logic [SiteWidth-1:0]  site_id;
      logic [CountWidth-1:0] mismatches;
      logic                  in_list;
      logic [BinWidth-1:0]   bin_count;
      logic                  list_complete;
      logic                  last;
   } rsp_item_type;

   localparam logic KindHit = 1'b0;
   localparam logic KindSummary = 1'b1;

   function automatic logic [BinWidth-1:0] sat_inc(input logic [BinWidth-1:0] v);
      return (v == {BinWidth{1'b1}}) ? v : v + 1'b1;
   endfunction

   function automatic logic [CountWidth-1:0] popcount64(input logic [WordWidth-1:0] v);
      logic [3:0]            byte_cnt [8];
      logic [CountWidth-1:0] sum;
      sum = '0;
      for (int i = 0; i < 8; i++) begin
         byte_cnt[i] = '0;
         for (int j = 0; j < 8; j++) begin
            byte_cnt[i] = byte_cnt[i] + 4'(v[8*i+j]);
         end
      end
      for (int i = 0; i < 8; i++) begin
         sum = sum + CountWidth'(byte_cnt[i]);
      end
      return sum;
   endfunction

endpackage

// ===== src/mhss_fifo.sv =====
module mhss_fifo #(
   parameter int Width = 8,
   parameter int Depth = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [Width-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output logic [Width-1:0] head
);

   localparam int AddrWidth = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CountBits = $clog2(Depth + 1);

   logic [Width-1:0]     mem_ff [Depth];
   logic [AddrWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AddrWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CountBits-1:0] count_ff, count_in;
   logic                 do_push, do_pop;

   assign full = (count_ff == CountBits'(Depth));
   assign empty = (count_ff == '0);
   assign head = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AddrWidth'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AddrWidth'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== src/mhss_front.sv =====
module mhss_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  logic [63:0]           entry_word,
   input  logic [31:0]           entry_index,
   input  logic                  last_entry,
   input  logic [63:0]           query_fwd,
   input  logic [63:0]           query_rev,
   input  logic [4:0]            seq_len,
   input  logic [31:0]           id_offset,
   input  logic [63:0]           error_word,
   input  logic                  q_full,
   output logic                  q_push,
   output mhss_pkg::fe_item_type q_item
);

   logic        valid_ff, valid_in;
   logic [63:0] diff_ff;
   logic        check_ff;
   logic [32:0] site_ff;
   logic        last_ff;
   logic        advance, accept;
   logic [63:0] orient, diff_fwd, diff_sel;

   assign advance = !valid_ff || !q_full;
   assign full = !advance;
   assign accept = push && advance;
   assign valid_in = advance ? accept : valid_ff;

   always_comb begin
      orient = 64'd1 << {seq_len, 1'b0};
      diff_fwd = query_fwd ^ entry_word;
      diff_sel = ((diff_fwd & orient) != '0) ? (query_rev ^ entry_word) : diff_fwd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         diff_ff <= diff_sel & ~orient;
         check_ff <= (entry_word != error_word);
         site_ff <= 33'(entry_index) + 33'(id_offset);
         last_ff <= last_entry;
      end
   end

   always_comb begin
      q_push = valid_ff && !q_full;
      q_item.check = check_ff;
      q_item.mm = mhss_pkg::popcount64(diff_ff);
      q_item.site_id = site_ff;
      q_item.last = last_ff;
   end

endmodule

// ===== src/mhss_back.sv =====
module mhss_back #(
   parameter int MaxMismatches = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_valid,
   input  mhss_pkg::fe_item_type  q_item,
   output logic                   q_pop,
   input  logic [15:0]            list_limit,
   input  logic                   out_full,
   output logic                   out_push,
   output mhss_pkg::rsp_item_type out_item
);

   localparam int NumBins = MaxMismatches + 1;
   localparam int BinIdxWidth = (NumBins > 1) ? $clog2(NumBins) : 1;

   typedef enum logic {
      ST_ITEM,
      ST_SUM
   } state_type;

   state_type              state_ff, state_in;
   logic [BinIdxWidth-1:0] bin_idx_ff, bin_idx_in;
   logic [31:0]            bins_ff [NumBins];
   logic [31:0]            bins_in [NumBins];
   logic [31:0]            total_ff, total_in;
   logic [31:0]            new_total;
   logic                   hit;
   logic [BinIdxWidth-1:0] hit_bin;
   logic                   last_bin;

   always_comb begin
      hit = q_item.check && (q_item.mm <= 7'(MaxMismatches));
      hit_bin = BinIdxWidth'(q_item.mm);
      new_total = mhss_pkg::sat_inc(total_ff);
      last_bin = (bin_idx_ff == BinIdxWidth'(MaxMismatches));
      q_pop = 1'b0;
      out_push = 1'b0;
      out_item = '0;
      state_in = state_ff;
      bin_idx_in = bin_idx_ff;
      bins_in = bins_ff;
      total_in = total_ff;
      case (state_ff)
         ST_ITEM: begin
            if (q_valid && !(hit && out_full)) begin
               if (hit) begin
                  out_push = 1'b1;
                  out_item.kind = mhss_pkg::KindHit;
                  out_item.site_id = q_item.site_id;
                  out_item.mismatches = q_item.mm;
                  out_item.in_list = (new_total < {16'd0, list_limit});
                  total_in = new_total;
                  for (int b = 0; b < NumBins; b++) begin
                     if (hit_bin == BinIdxWidth'(b)) begin
                        bins_in[b] = mhss_pkg::sat_inc(bins_ff[b]);
                     end
                  end
               end
               if (q_item.last) begin
                  state_in = ST_SUM;
                  bin_idx_in = '0;
               end else begin
                  q_pop = 1'b1;
               end
            end
         end
         ST_SUM: begin
            if (!out_full) begin
               out_push = 1'b1;
               out_item.kind = mhss_pkg::KindSummary;
               out_item.mismatches = 7'(bin_idx_ff);
               out_item.bin_count = bins_ff[bin_idx_ff];
               out_item.list_complete = (total_ff < {16'd0, list_limit});
               out_item.last = last_bin;
               if (last_bin) begin
                  q_pop = 1'b1;
                  state_in = ST_ITEM;
                  bin_idx_in = '0;
                  total_in = '0;
                  for (int b = 0; b < NumBins; b++) begin
                     bins_in[b] = '0;
                  end
               end else begin
                  bin_idx_in = bin_idx_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_ITEM;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_ITEM;
         bin_idx_ff <= '0;
         total_ff <= '0;
         for (int b = 0; b < NumBins; b++) begin
            bins_ff[b] <= '0;
         end
      end else begin
         state_ff <= state_in;
         bin_idx_ff <= bin_idx_in;
         total_ff <= total_in;
         bins_ff <= bins_in;
      end
   end

   a_pop_needs_item: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("Queue popped while empty.");

   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      out_push |-> !out_full)
      else $error("Result written while the output queue is full.");

   a_sum_holds_item: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SUM) |-> q_valid)
      else $error("Summary phase without a pending last request.");

   a_bin_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SUM) |-> (bin_idx_ff <= BinIdxWidth'(MaxMismatches)))
      else $error("Summary bin index out of range.");

   a_clear_after_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SUM && !out_full && last_bin) |=> (total_ff == '0))
      else $error("Hit total not cleared after the final summary.");

endmodule

// ===== src/mismatch_histogram_site_scan.sv =====
// A hit result reaches the result ports through the front register, item and result queues.
// One request per cycle is taken while the front can advance; a last request holds the back
// end for its hit, if any, and one summary per bin, one result per cycle while the result queue has room.
// The request and result queues hold four entries each and set the stall behavior.
// Synchronous reset clears bins, hit total and queues and loads register defaults.
module mismatch_histogram_site_scan #(
   parameter int MaxMismatches = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [63:0] req_entry_word,
   input  logic [31:0] req_entry_index,
   input  logic        req_last_entry,
   output logic        empty,
   input  logic        pop,
   output logic        rsp_kind,
   output logic [32:0] rsp_site_id,
   output logic [6:0]  rsp_mismatches,
   output logic        rsp_in_list,
   output logic [31:0] rsp_bin_count,
   output logic        rsp_list_complete,
   output logic        rsp_last,
   input  logic        valid,
   output logic        ready,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data
);

   localparam int QueueDepth = 4;

   logic [63:0] query_fwd_ff;
   logic [63:0] query_rev_ff;
   logic [4:0]  seq_len_ff;
   logic [31:0] id_offset_ff;
   logic [15:0] list_limit_ff;
   logic [63:0] error_word_ff;

   logic                   fq_push, fq_full, fq_pop, fq_empty;
   mhss_pkg::fe_item_type  fq_in, fq_head;
   logic                   rq_push, rq_full;
   mhss_pkg::rsp_item_type rq_in, rq_head;

   assign ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         query_fwd_ff <= '0;
         query_rev_ff <= '0;
         seq_len_ff <= 5'd20;
         id_offset_ff <= '0;
         list_limit_ff <= 16'd2000;
         error_word_ff <= '1;
      end else if (valid && ready) begin
         case (csr_index)
            mhss_pkg::CSR_QUERY_FWD:  query_fwd_ff <= csr_data;
            mhss_pkg::CSR_QUERY_REV:  query_rev_ff <= csr_data;
            mhss_pkg::CSR_SEQ_LEN:    seq_len_ff <= csr_data[4:0];
            mhss_pkg::CSR_ID_OFFSET:  id_offset_ff <= csr_data[31:0];
            mhss_pkg::CSR_LIST_LIMIT: list_limit_ff <= csr_data[15:0];
            mhss_pkg::CSR_ERROR_WORD: error_word_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   mhss_front u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .full        (full),
      .entry_word  (req_entry_word),
      .entry_index (req_entry_index),
      .last_entry  (req_last_entry),
      .query_fwd   (query_fwd_ff),
      .query_rev   (query_rev_ff),
      .seq_len     (seq_len_ff),
      .id_offset   (id_offset_ff),
      .error_word  (error_word_ff),
      .q_full      (fq_full),
      .q_push      (fq_push),
      .q_item      (fq_in)
   );

   mhss_fifo #(
      .Width ($bits(mhss_pkg::fe_item_type)),
      .Depth (QueueDepth)
   ) u_item_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (fq_push),
      .push_data (fq_in),
      .full      (fq_full),
      .pop       (fq_pop),
      .empty     (fq_empty),
      .head      (fq_head)
   );

   mhss_back #(
      .MaxMismatches (MaxMismatches)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (!fq_empty),
      .q_item     (fq_head),
      .q_pop      (fq_pop),
      .list_limit (list_limit_ff),
      .out_full   (rq_full),
      .out_push   (rq_push),
      .out_item   (rq_in)
   );

   mhss_fifo #(
      .Width ($bits(mhss_pkg::rsp_item_type)),
      .Depth (QueueDepth)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rq_push),
      .push_data (rq_in),
      .full      (rq_full),
      .pop       (pop),
      .empty     (empty),
      .head      (rq_head)
   );

   always_comb begin
      rsp_kind = rq_head.kind;
      rsp_site_id = rq_head.site_id;
      rsp_mismatches = rq_head.mismatches;
      rsp_in_list = rq_head.in_list;
      rsp_bin_count = rq_head.bin_count;
      rsp_list_complete = rq_head.list_complete;
      rsp_last = rq_head.last;
   end

endmodule

// ===== verif/mismatch_histogram_site_scan_tb.sv =====
module mismatch_histogram_site_scan_tb;

   localparam int MaxMm = 4;
   localparam int StallLimit = 2000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        full;
   logic [63:0] req_entry_word = '0;
   logic [31:0] req_entry_index = '0;
   logic        req_last_entry = 1'b0;
   logic        empty;
   logic        pop = 1'b0;
   logic        rsp_kind;
   logic [32:0] rsp_site_id;
   logic [6:0]  rsp_mismatches;
   logic        rsp_in_list;
   logic [31:0] rsp_bin_count;
   logic        rsp_list_complete;
   logic        rsp_last;
   logic        valid = 1'b0;
   logic        ready;
   logic [2:0]  csr_index = '0;
   logic [63:0] csr_data = '0;

   logic [63:0] cfg_query_fwd = '0;
   logic [63:0] cfg_query_rev = '0;
   logic [4:0]  cfg_seq_len = 5'd20;
   logic [31:0] cfg_id_offset = '0;
   logic [15:0] cfg_list_limit = 16'd2000;
   logic [63:0] cfg_error_word = '1;
   logic [31:0] bin_tally [MaxMm+1];
   logic [31:0] hit_tally = '0;

   mhss_pkg::rsp_item_type pending_results [$];
   int mismatch_count = 0;
   int stall_cycles = 0;
   int rsp_hold = 0;
   int pop_pause = 0;
   bit req_idle_on = 1'b1;
   bit rsp_idle_on = 1'b1;

   mismatch_histogram_site_scan #(
      .MaxMismatches(MaxMm)
   ) dut (
      .clock(clock),
      .reset(reset),
      .push(push),
      .full(full),
      .req_entry_word(req_entry_word),
      .req_entry_index(req_entry_index),
      .req_last_entry(req_last_entry),
      .empty(empty),
      .pop(pop),
      .rsp_kind(rsp_kind),
      .rsp_site_id(rsp_site_id),
      .rsp_mismatches(rsp_mismatches),
      .rsp_in_list(rsp_in_list),
      .rsp_bin_count(rsp_bin_count),
      .rsp_list_complete(rsp_list_complete),
      .rsp_last(rsp_last),
      .valid(valid),
      .ready(ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic logic [63:0] rand_word();
      return {$urandom, $urandom};
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = int'($urandom_range(0, 99));
      if (roll < 60) begin
         return 0;
      end else if (roll < 92) begin
         return int'($urandom_range(1, 3));
      end else begin
         return int'($urandom_range(10, 40));
      end
   endfunction

   function automatic logic [63:0] near_query(input bit from_rev, input int flips);
      logic [63:0] w;
      int          pos;
      int          orient_pos;
      orient_pos = 2 * int'(cfg_seq_len);
      w = from_rev ? cfg_query_rev : cfg_query_fwd;
      for (int i = 0; i < flips; i++) begin
         pos = int'($urandom_range(0, 63));
         if (pos != orient_pos) begin
            w[pos] = ~w[pos];
         end
      end
      return w;
   endfunction

   task automatic predict_scan_step(input logic [63:0] word, input logic [31:0] idx,
                                    input logic is_last);
      logic [63:0]            orient;
      logic [63:0]            diff;
      int                     mm;
      logic                   complete;
      mhss_pkg::rsp_item_type r;
      if (word != cfg_error_word) begin
         orient = 64'd1 << {cfg_seq_len, 1'b0};
         diff = cfg_query_fwd ^ word;
         if ((diff & orient) != '0) begin
            diff = cfg_query_rev ^ word;
         end
         mm = $countones(diff & ~orient);
         if (mm <= MaxMm) begin
            if (bin_tally[mm] != '1) begin
               bin_tally[mm] = bin_tally[mm] + 1'b1;
            end
            if (hit_tally != '1) begin
               hit_tally = hit_tally + 1'b1;
            end
            r = '0;
            r.kind = mhss_pkg::KindHit;
            r.site_id = {1'b0, idx} + {1'b0, cfg_id_offset};
            r.mismatches = 7'(mm);
            r.in_list = (hit_tally < {16'd0, cfg_list_limit});
            pending_results.insert(pending_results.size(), r);
         end
      end
      if (is_last) begin
         complete = (hit_tally < {16'd0, cfg_list_limit});
         for (int b = 0; b <= MaxMm; b++) begin
            r = '0;
            r.kind = mhss_pkg::KindSummary;
            r.mismatches = 7'(b);
            r.bin_count = bin_tally[b];
            r.list_complete = complete;
            r.last = (b == MaxMm);
            pending_results.insert(pending_results.size(), r);
         end
         for (int b = 0; b <= MaxMm; b++) begin
            bin_tally[b] = '0;
         end
         hit_tally = '0;
      end
   endtask

   task automatic send_entry(input logic [63:0] word, input logic [31:0] idx,
                             input logic is_last);
      @(negedge clock);
      push = 1'b1;
      req_entry_word = word;
      req_entry_index = idx;
      req_last_entry = is_last;
      do @(posedge clock); while (full);
      predict_scan_step(word, idx, is_last);
   endtask

   task automatic sender_gap();
      int n;
      n = req_idle_on ? pick_gap() : 0;
      if (n > 0) begin
         @(negedge clock);
         push = 1'b0;
         repeat (n - 1) @(negedge clock);
      end
   endtask

   task automatic drain_results();
      @(negedge clock);
      push = 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      // Requests that produce no result may still be inside the block.
      repeat (16) @(posedge clock);
   endtask

   task automatic write_reg(input mhss_pkg::csr_index_type idx, input logic [63:0] data);
      @(negedge clock);
      valid = 1'b1;
      csr_index = idx;
      csr_data = data;
      do @(posedge clock); while (!ready);
      case (idx)
         mhss_pkg::CSR_QUERY_FWD:  cfg_query_fwd = data;
         mhss_pkg::CSR_QUERY_REV:  cfg_query_rev = data;
         mhss_pkg::CSR_SEQ_LEN:    cfg_seq_len = data[4:0];
         mhss_pkg::CSR_ID_OFFSET:  cfg_id_offset = data[31:0];
         mhss_pkg::CSR_LIST_LIMIT: cfg_list_limit = data[15:0];
         mhss_pkg::CSR_ERROR_WORD: cfg_error_word = data;
         default: ;
      endcase
      @(negedge clock);
      valid = 1'b0;
   endtask

   task automatic load_queries();
      logic [63:0] fwd;
      logic [63:0] rev;
      int          pos;
      pos = 2 * int'(cfg_seq_len);
      fwd = rand_word();
      rev = rand_word();
      rev[pos] = ~fwd[pos];
      write_reg(mhss_pkg::CSR_QUERY_FWD, fwd);
      write_reg(mhss_pkg::CSR_QUERY_REV, rev);
   endtask

   task automatic configure_scan(input logic [4:0] seq, input logic [31:0] offset,
                                 input logic [15:0] limit, input logic [63:0] err);
      drain_results();
      write_reg(mhss_pkg::CSR_SEQ_LEN, {59'd0, seq});
      load_queries();
      write_reg(mhss_pkg::CSR_ID_OFFSET, {32'd0, offset});
      write_reg(mhss_pkg::CSR_LIST_LIMIT, {48'd0, limit});
      write_reg(mhss_pkg::CSR_ERROR_WORD, err);
   endtask

   task automatic run_scan(input int count);
      int          roll;
      logic [63:0] word;
      repeat (count) begin
         roll = int'($urandom_range(0, 99));
         if (roll < 70) begin
            word = near_query(1'($urandom_range(0, 1)), int'($urandom_range(0, 6)));
         end else if (roll < 80) begin
            word = cfg_error_word;
         end else begin
            word = rand_word();
         end
         send_entry(word, $urandom, ($urandom_range(0, 24) == 0));
         sender_gap();
      end
      send_entry(near_query(1'($urandom_range(0, 1)), int'($urandom_range(0, 4))),
                 $urandom, 1'b1);
   endtask

   task automatic test_reset_defaults();
      send_entry(64'd0, 32'd0, 1'b0);
      send_entry('1, 32'd1, 1'b0);
      send_entry(64'h0000_0000_0000_000F, 32'hFFFF_FFFF, 1'b0);
      send_entry(64'h0000_0000_0000_001F, 32'd5, 1'b0);
      send_entry((64'd1 << 40) | 64'd3, 32'd6, 1'b0);
      send_entry('1, 32'd7, 1'b1);
   endtask

   task automatic test_field_extremes();
      drain_results();
      write_reg(mhss_pkg::CSR_SEQ_LEN, 64'd31);
      load_queries();
      write_reg(mhss_pkg::CSR_ID_OFFSET, 64'hFFFF_FFFF);
      write_reg(mhss_pkg::CSR_LIST_LIMIT, 64'd1);
      write_reg(mhss_pkg::CSR_ERROR_WORD, 64'd0);
      send_entry(cfg_query_fwd, 32'hFFFF_FFFF, 1'b0);
      send_entry(cfg_query_rev, 32'd0, 1'b0);
      send_entry(near_query(1'b0, 4), 32'd2, 1'b0);
      send_entry(64'd0, 32'd3, 1'b0);
      send_entry(near_query(1'b1, 1), 32'd4, 1'b1);
   endtask

   task automatic test_zero_length_and_limit();
      drain_results();
      write_reg(mhss_pkg::CSR_SEQ_LEN, 64'd0);
      load_queries();
      write_reg(mhss_pkg::CSR_LIST_LIMIT, 64'd0);
      write_reg(mhss_pkg::CSR_ERROR_WORD, rand_word());
      send_entry(cfg_query_fwd, 32'd10, 1'b0);
      send_entry(cfg_query_rev, 32'd11, 1'b0);
      send_entry(cfg_query_fwd ^ 64'd1, 32'd12, 1'b0);
      send_entry(near_query(1'b0, 3), 32'd13, 1'b0);
      send_entry(cfg_error_word, 32'd14, 1'b1);
   endtask

   task automatic test_random_scans();
      configure_scan(5'd20, $urandom, 16'hFFFF, rand_word());
      run_scan(90);
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      configure_scan(5'd1, 32'd0, 16'd3, '1);
      run_scan(90);
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      configure_scan(5'd31, 32'hFFFF_FFFF, 16'd5, rand_word());
      run_scan(90);
      configure_scan(5'($urandom_range(1, 31)), $urandom, 16'($urandom_range(1, 40)), 64'd0);
      write_reg(mhss_pkg::CSR_ERROR_WORD, cfg_query_fwd);
      run_scan(90);
      configure_scan(5'($urandom_range(1, 31)), $urandom, 16'($urandom_range(1, 65535)),
                     rand_word());
      run_scan(90);
   endtask

   task automatic test_input_stall();
      drain_results();
      req_idle_on = 1'b0;
      rsp_hold = 300;
      repeat (40) begin
         send_entry(near_query(1'($urandom_range(0, 1)), int'($urandom_range(0, 2))),
                    $urandom, 1'b0);
      end
      send_entry(near_query(1'b0, 1), $urandom, 1'b1);
      req_idle_on = 1'b1;
   endtask

   initial begin
      forever begin
         @(negedge clock);
         if (rsp_hold > 0) begin
            pop = 1'b0;
            rsp_hold--;
         end else if (pop_pause > 0) begin
            pop = 1'b0;
            pop_pause--;
         end else if (rsp_idle_on && $urandom_range(0, 3) == 0) begin
            pop = 1'b0;
            pop_pause = pick_gap();
         end else begin
            pop = 1'b1;
         end
      end
   end

   always @(posedge clock) begin : check_results
      mhss_pkg::rsp_item_type got;
      mhss_pkg::rsp_item_type want;
      bit                     progress;
      if (!reset) begin
         progress = (push && !full) || (valid && ready);
         if (pop && !empty) begin
            progress = 1'b1;
            got.kind = rsp_kind;
            got.site_id = rsp_site_id;
            got.mismatches = rsp_mismatches;
            got.in_list = rsp_in_list;
            got.bin_count = rsp_bin_count;
            got.list_complete = rsp_list_complete;
            got.last = rsp_last;
            if (pending_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("unexpected result: %p", got);
               end
            end else begin
               want = pending_results[0];
               pending_results.delete(0);
               if (got.kind !== want.kind || got.site_id !== want.site_id ||
                   got.mismatches !== want.mismatches || got.in_list !== want.in_list ||
                   got.bin_count !== want.bin_count ||
                   got.list_complete !== want.list_complete || got.last !== want.last) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("result mismatch: expected %p, actual %p", want, got);
                  end
               end
            end
         end
         stall_cycles = progress ? 0 : stall_cycles + 1;
         if (stall_cycles >= StallLimit) begin
            $display("[mismatch_histogram_site_scan] ERROR");
            $finish;
         end
      end
   end

   initial begin
      for (int b = 0; b <= MaxMm; b++) begin
         bin_tally[b] = '0;
      end
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_reset_defaults();
      test_field_extremes();
      test_zero_length_and_limit();
      test_random_scans();
      test_input_stall();
      drain_results();
      if (mismatch_count == 0) begin
         $display("[mismatch_histogram_site_scan] OK");
      end else begin
         $display("[mismatch_histogram_site_scan] ERROR");
      end
      $finish;
   end

endmodule

// ===== files.f =====
src/mhss_pkg.sv
src/mhss_fifo.sv
src/mhss_front.sv
src/mhss_back.sv
src/mismatch_histogram_site_scan.sv
verif/mismatch_histogram_site_scan_tb.sv
